// ===== rtl/pfcb_pkg.sv =====
// Package for the page framebuffer column blit.
// Holds frame geometry constants, controller states and the command and
// status structs shared by the controller and the datapath. No dependencies.
package pfcb_pkg;

    localparam int PAGES   = 8;
    localparam int COLUMNS = 128;
    localparam int DEPTH   = PAGES * COLUMNS;
    localparam int ADDR_W  = $clog2(DEPTH);

    localparam int BYTE_W   = 8;
    localparam int ROW_W    = 6;
    localparam int COL_W    = 8;
    localparam int HEIGHT_W = 4;
    localparam int RPAGE_W  = 3;

    // Comparison constants, sized to hold the largest legal parameter value.
    localparam logic [8:0] COLUMNS_CMP = 9'(COLUMNS);
    localparam logic [4:0] PAGES_CMP   = 5'(PAGES);
    localparam logic [3:0] MAX_HEIGHT  = 4'd8;

    localparam logic FUNC_DRAW = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR_A,
        ST_WR_B
    } state_t;

    typedef struct packed {
        logic take;       // latch the item and read the first page byte
        logic wr_a;       // write the merged first page byte
        logic rd_b;       // read the second page byte
        logic wr_b;       // write the merged second page byte
        logic load_res;   // load the result of the latched item
        logic load_ign;   // load an ignored result
        logic clr_step;   // write one zero byte of the clearing pass
    } cmd_t;

    typedef struct packed {
        logic in_ign;     // the offered item has no effect
        logic is_read;    // the latched item is a read
        logic spill;      // the latched draw touches a second page
        logic clr_done;   // the clearing pass is on its last entry
    } sts_t;

endpackage

// ===== rtl/pfcb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the frame store; depends on nothing else.
module pfcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/pfcb_ctrl.sv =====
// Controller for the page framebuffer column blit.
// Sequences the clearing pass, the read-modify-write of one or two page
// bytes and the result register handshake. Depends on pfcb_pkg.
module pfcb_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    input  pfcb_pkg::sts_t sts,
    output pfcb_pkg::cmd_t cmd
);

    import pfcb_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // An item is taken only when the result register will be free at the
    // next edge, so the result of this item can always be loaded.
    assign in_stall = !((state_reg == ST_IDLE) && (!out_valid_reg || !out_stall));
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (sts.in_ign)
                    begin
                        cmd.load_ign = 1'b1;
                    end
                    else
                    begin
                        cmd.take   = 1'b1;
                        state_next = ST_WR_A;
                    end
                end
            end
            ST_WR_A:
            begin
                if (sts.is_read)
                begin
                    cmd.load_res = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    cmd.wr_a = 1'b1;
                    if (sts.spill)
                    begin
                        cmd.rd_b   = 1'b1;
                        state_next = ST_WR_B;
                    end
                    else
                    begin
                        cmd.load_res = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end
            ST_WR_B:
            begin
                cmd.wr_b     = 1'b1;
                cmd.load_res = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_res || cmd.load_ign)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/pfcb_dp.sv =====
// Datapath for the page framebuffer column blit.
// Holds the item registers, the merge logic, the display style register,
// the result register and the frame store RAM. Depends on pfcb_pkg, pfcb_ram.
module pfcb_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          func,
    input  logic [pfcb_pkg::ROW_W-1:0]    pixel_row,
    input  logic [pfcb_pkg::COL_W-1:0]    column,
    input  logic [pfcb_pkg::HEIGHT_W-1:0] bit_height,
    input  logic [pfcb_pkg::BYTE_W-1:0]   pixels,
    input  logic                          clear,
    input  logic                          invert,
    input  logic [pfcb_pkg::RPAGE_W-1:0]  read_page,
    input  logic                          cfg_we,
    input  logic                          cfg_data,
    input  pfcb_pkg::cmd_t                cmd,
    output pfcb_pkg::sts_t                sts,
    output logic [pfcb_pkg::BYTE_W-1:0]   read_data,
    output logic                          ignored
);

    import pfcb_pkg::*;

    logic [2:0]          draw_page;
    logic [2:0]          sel_page;
    logic [2:0]          bit_off;
    logic [HEIGHT_W-1:0] height_sat;
    logic [BYTE_W-1:0]   src;
    logic [15:0]         data_in;
    logic [15:0]         mask_in;
    logic                col_bad;
    logic                page_bad;
    logic                next_page_ok;
    logic [ADDR_W-1:0]   addr_in;

    logic [15:0]         data_reg;
    logic [15:0]         mask_reg;
    logic [ADDR_W-1:0]   addr_a_reg;
    logic [ADDR_W-1:0]   addr_b_reg;
    logic                is_read_reg;
    logic                spill_reg;
    logic                disp_inv_reg;
    logic [ADDR_W-1:0]   clr_cnt_reg;
    logic [BYTE_W-1:0]   read_data_reg;
    logic                ignored_reg;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [BYTE_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [BYTE_W-1:0]   ram_rdata;
    logic [BYTE_W-1:0]   merge_a;
    logic [BYTE_W-1:0]   merge_b;

    // Decode of the offered item.
    assign draw_page  = pixel_row[ROW_W-1:3];
    assign bit_off    = pixel_row[2:0];
    assign sel_page   = (func == FUNC_READ) ? read_page : draw_page;
    assign height_sat = (bit_height > MAX_HEIGHT) ? MAX_HEIGHT : bit_height;

    always_comb
    begin
        src = clear ? '0 : pixels;
        if (invert)
        begin
            src = ~src;
        end
    end

    // The run is placed in a 16-bit window; the upper byte is the spill
    // into the next page.
    assign data_in = {8'd0, src} << bit_off;
    assign mask_in = ((16'd1 << height_sat) - 16'd1) << bit_off;

    assign col_bad      = {1'b0, column} >= COLUMNS_CMP;
    assign page_bad     = {2'b00, sel_page} >= PAGES_CMP;
    assign next_page_ok = ({2'b00, draw_page} + 5'd1) < PAGES_CMP;
    assign addr_in      = ADDR_W'(sel_page) * ADDR_W'(COLUMNS) + ADDR_W'(column);

    always_comb
    begin
        sts.in_ign = col_bad || page_bad;
        if (func == FUNC_DRAW && bit_height == '0)
        begin
            sts.in_ign = 1'b1;
        end
        sts.is_read  = is_read_reg;
        sts.spill    = spill_reg;
        sts.clr_done = (clr_cnt_reg == ADDR_W'(DEPTH - 1));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            data_reg    <= data_in;
            mask_reg    <= mask_in;
            addr_a_reg  <= addr_in;
            addr_b_reg  <= addr_in + ADDR_W'(COLUMNS);
            is_read_reg <= func;
            spill_reg   <= (mask_in[15:8] != 8'd0) && next_page_ok;
        end
        if (cmd.load_ign)
        begin
            read_data_reg <= '0;
            ignored_reg   <= 1'b1;
        end
        else if (cmd.load_res)
        begin
            read_data_reg <= is_read_reg ? (ram_rdata ^ {BYTE_W{disp_inv_reg}}) : '0;
            ignored_reg   <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disp_inv_reg <= 1'b0;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                disp_inv_reg <= cfg_data;
            end
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
        end
    end

    assign merge_a = (ram_rdata & ~mask_reg[7:0])  | (data_reg[7:0]  & mask_reg[7:0]);
    assign merge_b = (ram_rdata & ~mask_reg[15:8]) | (data_reg[15:8] & mask_reg[15:8]);

    // The second page read is issued while the first page is written.
    assign ram_raddr = cmd.rd_b ? addr_b_reg : addr_in;
    assign ram_we    = cmd.clr_step || cmd.wr_a || cmd.wr_b;

    always_comb
    begin
        if (cmd.clr_step)
        begin
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else if (cmd.wr_b)
        begin
            ram_waddr = addr_b_reg;
            ram_wdata = merge_b;
        end
        else
        begin
            ram_waddr = addr_a_reg;
            ram_wdata = merge_a;
        end
    end

    pfcb_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(DEPTH)
    ) u_frame_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign read_data = read_data_reg;
    assign ignored   = ignored_reg;

endmodule

// ===== rtl/page_framebuffer_column_blit.sv =====
// Page-mode monochrome frame store with a single-column bit blit.
// Usage: an input word (func, pixel_row, column, bit_height, pixels, clear,
// invert, read_page) is taken when in_valid is high and in_stall is low.
// Each input word gives exactly one output word (read_data, ignored), held
// on out_valid until a cycle in which out_stall is low.
// After accept, an ignored word loads the output register from ST_IDLE; a
// read or a draw within one page passes through ST_WR_A, and a draw that
// spills into a second page through ST_WR_A and ST_WR_B. A new word is taken
// only in ST_IDLE, as the read-modify-write uses the single write port.
// A new word is taken while the previous result still waits, as long as
// that result is taken in the same cycle or the output register is empty.
// A stalled receiver holds the output word and, once a new result is due,
// holds off the sender through in_stall.
// The display_invert register is written over cfg_valid/cfg_ready/cfg_data;
// cfg_ready is always high. Write it only while the block is idle.
// After reset the frame store is cleared, one byte per cycle, over all
// PAGES*COLUMNS (1024) entries; in_stall stays high during that pass.
// Depends on pfcb_pkg, pfcb_ctrl, pfcb_dp and pfcb_ram.
module page_framebuffer_column_blit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          func,
    input  logic [pfcb_pkg::ROW_W-1:0]    pixel_row,
    input  logic [pfcb_pkg::COL_W-1:0]    column,
    input  logic [pfcb_pkg::HEIGHT_W-1:0] bit_height,
    input  logic [pfcb_pkg::BYTE_W-1:0]   pixels,
    input  logic                          clear,
    input  logic                          invert,
    input  logic [pfcb_pkg::RPAGE_W-1:0]  read_page,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pfcb_pkg::BYTE_W-1:0]   read_data,
    output logic                          ignored,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data
);

    import pfcb_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    pfcb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    pfcb_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .func      (func),
        .pixel_row (pixel_row),
        .column    (column),
        .bit_height(bit_height),
        .pixels    (pixels),
        .clear     (clear),
        .invert    (invert),
        .read_page (read_page),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .read_data (read_data),
        .ignored   (ignored)
    );

endmodule

// ===== tb/frame_blit_checker.sv =====
// Checker for the page framebuffer column blit: keeps its own copy of the frame
// store and the display style register and predicts one result word per input word.
// Depends on pfcb_pkg; watches the input, output and configuration channels.
module frame_blit_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          func,
    input  logic [pfcb_pkg::ROW_W-1:0]    pixel_row,
    input  logic [pfcb_pkg::COL_W-1:0]    column,
    input  logic [pfcb_pkg::HEIGHT_W-1:0] bit_height,
    input  logic [pfcb_pkg::BYTE_W-1:0]   pixels,
    input  logic                          clear,
    input  logic                          invert,
    input  logic [pfcb_pkg::RPAGE_W-1:0]  read_page,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [pfcb_pkg::BYTE_W-1:0]   read_data,
    input  logic                          ignored,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic                          cfg_data,
    output int                            mismatches,
    output int                            results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    import pfcb_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              ign;
    } blit_result_t;

    logic [BYTE_W-1:0] frame_copy [DEPTH];
    logic              show_inverted = 1'b0;
    blit_result_t      owed_results [$];
    int                fail_count = 0;

    assign mismatches   = fail_count;
    assign results_owed = owed_results.size();

    initial
    begin
        foreach (frame_copy[i])
            frame_copy[i] = '0;
    end

    function automatic logic [7:0] ones(input int unsigned n);
        return 8'((32'd1 << n) - 1);
    endfunction

    // Applies one word to the frame copy and returns the result it must give.
    function automatic blit_result_t blit_expected(
        input logic f, input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
        input logic [HEIGHT_W-1:0] h_in, input logic [BYTE_W-1:0] pix,
        input logic clr, input logic inv, input logic [RPAGE_W-1:0] rpage);
        blit_result_t r;
        int unsigned  h, pg, off, rem, idx;
        logic [7:0]   src, keep, take, mask;
        r.data = '0;
        r.ign  = 1'b1;
        if (f == FUNC_DRAW)
        begin
            h  = 32'((h_in > MAX_HEIGHT) ? MAX_HEIGHT : h_in);
            pg = 32'(row) >> 3;
            if (h != 0 && col < COLUMNS && pg < PAGES)
            begin
                off = 32'(row) & 7;
                rem = 8 - off;
                src = clr ? 8'h00 : pix;
                if (inv)
                    src = ~src;
                if (h < rem)
                begin
                    keep = ones(off) | 8'(ones(rem - h) << (off + h));
                    take = ones(h);
                end
                else
                begin
                    keep = ones(off);
                    take = ones(rem);
                end
                idx = pg * COLUMNS + 32'(col);
                frame_copy[idx] = (frame_copy[idx] & keep) | 8'((src & take) << off);
                // Bits that run past the page go to the next page, masked to the
                // rest of the height; below the last page they are dropped.
                if (h > rem && pg + 1 < PAGES)
                begin
                    mask = ones(h - rem);
                    idx  = idx + COLUMNS;
                    frame_copy[idx] = (frame_copy[idx] & ~mask) | ((src >> rem) & mask);
                end
                r.ign = 1'b0;
            end
        end
        else if (col < COLUMNS && rpage < PAGES)
        begin
            r.data = frame_copy[32'(rpage) * COLUMNS + 32'(col)] ^ {BYTE_W{show_inverted}};
            r.ign  = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    // Every input changes only at a rising edge, so what is seen at the falling
    // edge is what the next rising edge takes.
    always @(negedge clk)
    begin
        blit_result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                show_inverted = cfg_data;
            // The output side goes first: a word taken at the same edge cannot
            // already have its result on the output.
            if (out_valid && !out_stall)
            begin
                if (owed_results.size() == 0)
                    report_mismatch($sformatf("result word read_data=%02h ignored=%b with none owed",
                                              read_data, ignored));
                else
                begin
                    want = owed_results.pop_front();
                    if (read_data !== want.data)
                        report_mismatch($sformatf("read_data %02h, expected %02h",
                                                  read_data, want.data));
                    if (ignored !== want.ign)
                        report_mismatch($sformatf("ignored %b, expected %b",
                                                  ignored, want.ign));
                end
            end
            if (in_valid && !in_stall)
                owed_results.push_back(blit_expected(func, pixel_row, column, bit_height,
                                                     pixels, clear, invert, read_page));
        end
    end

endmodule

// ===== tb/tb_page_framebuffer_column_blit.sv =====
// Top of the column blit testbench: clock, reset, word stimulus with random gaps
// and receiver stalls, and the verdict. Prediction and checking live in
// frame_blit_checker; depends on pfcb_pkg and the block itself.
module tb_page_framebuffer_column_blit;
    timeunit 1ns;
    timeprecision 1ps;

    import pfcb_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_WORDS    = 590;

    typedef struct packed {
        logic                func;
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
        logic [HEIGHT_W-1:0] height;
        logic [BYTE_W-1:0]   pix;
        logic                clr;
        logic                inv;
        logic [RPAGE_W-1:0]  page;
    } blit_word_t;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_stall;
    logic                func       = 1'b0;
    logic [ROW_W-1:0]    pixel_row  = '0;
    logic [COL_W-1:0]    column     = '0;
    logic [HEIGHT_W-1:0] bit_height = '0;
    logic [BYTE_W-1:0]   pixels     = '0;
    logic                clear      = 1'b0;
    logic                invert     = 1'b0;
    logic [RPAGE_W-1:0]  read_page  = '0;
    logic                out_valid;
    logic                out_stall  = 1'b0;
    logic [BYTE_W-1:0]   read_data;
    logic                ignored;
    logic                cfg_valid  = 1'b0;
    logic                cfg_ready;
    logic                cfg_data   = 1'b0;

    int mismatches;
    int results_owed;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_req    = 1'b0;

    page_framebuffer_column_blit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .pixel_row  (pixel_row),
        .column     (column),
        .bit_height (bit_height),
        .pixels     (pixels),
        .clear      (clear),
        .invert     (invert),
        .read_page  (read_page),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_data  (read_data),
        .ignored    (ignored),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    frame_blit_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .pixel_row    (pixel_row),
        .column       (column),
        .bit_height   (bit_height),
        .pixels       (pixels),
        .clear        (clear),
        .invert       (invert),
        .read_page    (read_page),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_data    (read_data),
        .ignored      (ignored),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .results_owed (results_owed)
    );

    initial
    begin
        forever
            #10 clk = ~clk;
    end

    // Receiver: random stalls, or one long hold-off when the stimulus asks for it.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Ends the run when no channel has moved a word for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(negedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    function automatic blit_word_t draw_word(input int row, input int col, input int h,
                                             input int pix, input bit clr, input bit inv);
        blit_word_t w;
        w        = '0;
        w.func   = FUNC_DRAW;
        w.row    = ROW_W'(row);
        w.col    = COL_W'(col);
        w.height = HEIGHT_W'(h);
        w.pix    = BYTE_W'(pix);
        w.clr    = clr;
        w.inv    = inv;
        return w;
    endfunction

    function automatic blit_word_t read_word(input int page, input int col);
        blit_word_t w;
        w      = '0;
        w.func = FUNC_READ;
        w.page = RPAGE_W'(page);
        w.col  = COL_W'(col);
        return w;
    endfunction

    // Called just after a rising edge; returns just after the edge that took the word.
    task automatic send_word(input blit_word_t w);
        logic stalled;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        {func, pixel_row, column, bit_height, pixels, clear, invert, read_page} <= w;
        do
        begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end
        while (stalled);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (results_owed != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_display_invert(input logic value);
        logic ready_seen;
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(negedge clk);
            ready_seen = cfg_ready;
            @(posedge clk);
        end
        while (!ready_seen);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input int hold_at);
        blit_word_t w;
        int         pick;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int n = 0; n < PHASE_WORDS; n++)
        begin
            if (n == hold_at)
                hold_req = 1'b1;
            w      = blit_word_t'($urandom);
            w.func = 1'($urandom_range(1));
            // About four words in ten land on columns 0 to 15 so that reads see earlier draws.
            pick = $urandom_range(9);
            if (pick >= 2 && pick <= 5)
                w.col = COL_W'($urandom_range(15));
            else if (pick > 5)
                w.col = COL_W'($urandom_range(COLUMNS - 1));
            pick = $urandom_range(19);
            if (pick == 0)
                w.height = '0;
            else if (pick == 1)
                w.height = HEIGHT_W'($urandom_range(15, 9));
            else
                w.height = HEIGHT_W'($urandom_range(8, 1));
            w.clr = ($urandom_range(6) == 0);
            w.inv = ($urandom_range(3) == 0);
            send_word(w);
        end
        drain();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        write_display_invert(1'b0);

        tx_idle_pct = 12;
        rx_idle_pct = 79;
        send_word(draw_word(0, 0, 8, 'hA5, 1'b0, 1'b0));
        send_word(read_word(0, 0));
        // Run at the bottom row: everything past the last page is dropped.
        send_word(draw_word(63, 127, 8, 'hFF, 1'b0, 1'b0));
        send_word(read_word(7, 127));
        // Run across a page boundary, then a short run inside the second page.
        send_word(draw_word(5, 5, 8, 'hFF, 1'b0, 1'b0));
        send_word(draw_word(12, 5, 3, 'h00, 1'b0, 1'b1));
        send_word(read_word(0, 5));
        send_word(read_word(1, 5));
        send_word(draw_word(20, 200, 4, 'h3C, 1'b0, 1'b0));
        send_word(read_word(3, 128));
        send_word(draw_word(9, 3, 0, 'hFF, 1'b0, 1'b0));
        // Height above eight saturates; clear with invert writes all ones.
        send_word(draw_word(3, 9, 15, 'h5A, 1'b1, 1'b1));
        send_word(read_word(1, 9));
        send_word(draw_word(3, 9, 2, 'hFF, 1'b1, 1'b0));
        send_word(read_word(0, 9));
        send_word(draw_word(63, 127, 1, 'h00, 1'b0, 1'b0));
        send_word(draw_word(56, 255, 8, 'hFF, 1'b1, 1'b1));
        drain();

        write_display_invert(1'b1);
        send_word(read_word(7, 127));
        send_word(read_word(0, 0));
        send_word(read_word(2, 5));
        send_word(read_word(7, 255));
        drain();

        run_phase(12, 79, -1);
        write_display_invert(1'b0);
        run_phase(79, 12, -1);
        write_display_invert(1'b1);
        run_phase(0, 0, 150);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== page_framebuffer_column_blit.f =====
rtl/pfcb_pkg.sv
rtl/pfcb_ram.sv
rtl/pfcb_ctrl.sv
rtl/pfcb_dp.sv
rtl/page_framebuffer_column_blit.sv
tb/frame_blit_checker.sv
tb/tb_page_framebuffer_column_blit.sv
